// File: rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for scanline filter reconstruction
// Sizes of the line store and the left-neighbor history, and filter codes.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // line store depth and derived widths
  localparam int MAX_ROW_BYTES   = 16384;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int ADDR_W          = $clog2(MAX_ROW_BYTES);
  localparam int ROW_W           = 15;
  localparam int PIX_W           = 4;
  localparam int SEL_W           = $clog2(MAX_PIXEL_BYTES) > 0 ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int HIST_W          = MAX_PIXEL_BYTES * 8;

  // configuration register indexes
  localparam logic REG_ROW_BYTES   = 1'b0;
  localparam logic REG_PIXEL_BYTES = 1'b1;

  // filter type codes carried by the first byte of each row
  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4
  } filter_t;

  // highest valid filter code
  localparam logic [7:0] FLT_MAX_CODE = 8'd4;

endpackage

// File: rtl/core/scanline_filter_reconstruct.sv
// ----------------------------------------------------------------------------
// scanline_filter_reconstruct: PNG scanline filter reconstruction
// Rebuilds filtered image bytes (None, Sub, Up, Average, Paeth) from the
// inflated byte stream, keeping the previous row in an on-chip line store.
//
//   channel | direction | tdata            | tlast   | tuser
//   in_     | input     | stream_byte      | -       | image_start
//   out_    | output    | pixel_byte       | row_end | bad_filter
//   cfg_    | input     | cfg_data, index on cfg_addr (0 row_bytes, 1 pixel_bytes)
//
// One byte per cycle sustained while the output is not stalled; a byte's result
// passes through the input register (line store read at accept) and then the
// output register. Row control runs at accept; prediction sits between the input
// register and the output register. The line store is a single-write,
// single-read memory.
// rst_n is synchronous; the line store is not cleared, no clearing pass.
// A stalled output holds its result; requests that give no result still pass,
// and in_tready drops while the input register holds a result that cannot move.
// ----------------------------------------------------------------------------
module scanline_filter_reconstruct
  import sfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] stream_byte
  input  logic             in_tuser,   // [0] image_start
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [7:0] pixel_byte
  output logic             out_tlast,  // row_end
  output logic             out_tuser,  // [0] bad_filter
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_addr,
  input  logic [ROW_W-1:0] cfg_data
);

  // kind of request held in the input register
  typedef enum logic [1:0] {
    OP_DROP  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_DATA  = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       byte_v;
    filter_t          kind;
    logic             first;
    logic             row_end;
    logic [SEL_W-1:0] sel;
    logic [ADDR_W-1:0] col;
  } s1_t;

  // configuration
  logic [ROW_W-1:0]  row_bytes_r;
  logic [PIX_W-1:0]  pixel_bytes_r;
  // row control
  logic [ADDR_W-1:0] column_r, column_nxt;
  filter_t           kind_r, kind_nxt;
  logic              first_row_r, first_row_nxt;
  logic              expect_r, expect_nxt;
  logic              halted_r, halted_nxt;
  // input register and line store read data
  logic              s1_v_r;
  s1_t               s1_r, s1_nxt;
  logic [7:0]        above_r;
  // histories
  logic [HIST_W-1:0] left_r;
  logic [HIST_W-1:0] upleft_r;
  // output register
  logic              out_v_r;
  logic [7:0]        out_data_r;
  logic              out_last_r;
  logic              out_bad_r;

  logic [7:0]        line_mem [MAX_ROW_BYTES];

  logic              in_acc;
  logic              s1_adv;
  logic              s1_res;
  logic [ROW_W-1:0]  eff_row;
  logic [SEL_W-1:0]  eff_sel;
  logic [ROW_W-1:0]  col_inc;
  logic [7:0]        a_byte, b_byte, c_byte, pred, x_byte;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r   <= ROW_W'(1);
      pixel_bytes_r <= PIX_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_ROW_BYTES:   row_bytes_r   <= cfg_data;
        REG_PIXEL_BYTES: pixel_bytes_r <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // effective row length and left-neighbor distance
  always_comb begin
    if (row_bytes_r == '0) begin
      eff_row = ROW_W'(1);
    end else if (row_bytes_r > ROW_W'(MAX_ROW_BYTES)) begin
      eff_row = ROW_W'(MAX_ROW_BYTES);
    end else begin
      eff_row = row_bytes_r;
    end
    if (pixel_bytes_r == '0) begin
      eff_sel = '0;
    end else if (pixel_bytes_r > PIX_W'(MAX_PIXEL_BYTES)) begin
      eff_sel = SEL_W'(MAX_PIXEL_BYTES - 1);
    end else begin
      eff_sel = SEL_W'(pixel_bytes_r - PIX_W'(1));
    end
  end

  // handshake: the input register drains into the output register
  assign s1_res    = (s1_r.op == OP_DATA) || (s1_r.op == OP_BAD);
  assign s1_adv    = s1_v_r && (!s1_res || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // row control at accept
  always_comb begin
    column_nxt    = column_r;
    kind_nxt      = kind_r;
    first_row_nxt = first_row_r;
    expect_nxt    = expect_r;
    halted_nxt    = halted_r;
    col_inc       = ROW_W'(column_r) + ROW_W'(1);
    s1_nxt        = '{op: OP_DROP, byte_v: in_tdata, kind: kind_r, first: 1'b0,
                      row_end: 1'b0, sel: eff_sel, col: column_r};
    if (in_tuser) begin
      first_row_nxt = 1'b1;
      expect_nxt    = 1'b1;
      halted_nxt    = 1'b0;
      column_nxt    = '0;
    end
    if (halted_nxt) begin
      s1_nxt.op = OP_DROP;
    end else if (expect_nxt) begin
      if (in_tdata > FLT_MAX_CODE) begin
        halted_nxt = 1'b1;
        s1_nxt.op  = OP_BAD;
      end else begin
        kind_nxt   = filter_t'(in_tdata[2:0]);
        expect_nxt = 1'b0;
        column_nxt = '0;
        s1_nxt.op  = OP_CLEAR;
      end
    end else begin
      s1_nxt.op    = OP_DATA;
      s1_nxt.first = first_row_nxt;
      if (col_inc >= eff_row) begin
        s1_nxt.row_end = 1'b1;
        column_nxt     = '0;
        expect_nxt     = 1'b1;
        first_row_nxt  = 1'b0;
      end else begin
        column_nxt = col_inc[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      kind_r      <= FLT_NONE;
      first_row_r <= 1'b1;
      expect_r    <= 1'b1;
      halted_r    <= 1'b0;
      s1_v_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        column_r    <= column_nxt;
        kind_r      <= kind_nxt;
        first_row_r <= first_row_nxt;
        expect_r    <= expect_nxt;
        halted_r    <= halted_nxt;
        s1_v_r      <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  // line store: read the row above at accept, write the rebuilt byte on advance
  always_ff @(posedge clk) begin
    if (in_acc && s1_nxt.op == OP_DATA) begin
      above_r <= line_mem[s1_nxt.col];
    end
    if (s1_adv && s1_r.op == OP_DATA) begin
      line_mem[s1_r.col] <= x_byte;
    end
  end

  // neighbors and reconstruction
  assign a_byte = left_r[{s1_r.sel, 3'b000} +: 8];
  assign c_byte = upleft_r[{s1_r.sel, 3'b000} +: 8];
  assign b_byte = s1_r.first ? 8'd0 : above_r;

  sfr_predict u_predict (
    .kind (s1_r.kind),
    .a    (a_byte),
    .b    (b_byte),
    .c    (c_byte),
    .pred (pred)
  );

  assign x_byte = s1_r.byte_v + pred;

  // history shift registers, cleared on each valid filter byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      upleft_r <= '0;
    end else if (s1_adv) begin
      if (s1_r.op == OP_CLEAR) begin
        left_r   <= '0;
        upleft_r <= '0;
      end else if (s1_r.op == OP_DATA) begin
        left_r   <= {left_r[HIST_W-9:0], x_byte};
        upleft_r <= {upleft_r[HIST_W-9:0], b_byte};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && s1_res) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res) begin
      out_data_r <= (s1_r.op == OP_BAD) ? 8'd0 : x_byte;
      out_last_r <= (s1_r.op == OP_DATA) && s1_r.row_end;
      out_bad_r  <= (s1_r.op == OP_BAD);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

  // an error result carries no pixel and no row end
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 8'd0 && !out_tlast))
    else $error("error result carries data");

  // a halted image stays halted until an image start is accepted
  a_halt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && !(in_acc && in_tuser)) |=> halted_r)
    else $error("halt released without image start");

  // waiting for a filter byte means the row position is back at zero
  a_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    expect_r |-> (column_r == '0))
    else $error("column not cleared at row boundary");

  // the input register only advances when the output side can take a result
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_res) |-> (!out_v_r || out_tready))
    else $error("result overwrote pending output");

endmodule

// File: rtl/core/sfr_predict.sv
// ----------------------------------------------------------------------------
// sfr_predict: filter predictor
// Forms the prediction from left (a), above (b) and above-left (c) bytes.
// ----------------------------------------------------------------------------
module sfr_predict
  import sfr_pkg::*;
(
  input  filter_t    kind,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] c,
  output logic [7:0] pred
);

  logic [8:0]        avg_sum;
  logic signed [9:0] pa_d;
  logic signed [9:0] pb_d;
  logic signed [9:0] pc_d;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [7:0]        paeth;

  // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
  always_comb begin
    pa_d = $signed({2'b00, b}) - $signed({2'b00, c});
    pb_d = $signed({2'b00, a}) - $signed({2'b00, c});
    pc_d = pa_d + pb_d;
    pa   = pa_d[9] ? 10'(-pa_d) : 10'(pa_d);
    pb   = pb_d[9] ? 10'(-pb_d) : 10'(pb_d);
    pc   = pc_d[9] ? 10'(-pc_d) : 10'(pc_d);
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  assign avg_sum = {1'b0, a} + {1'b0, b};

  // select by filter type
  always_comb begin
    case (kind)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = avg_sum[8:1];
      FLT_PAETH: pred = paeth;
      default:   pred = 8'd0;
    endcase
  end

endmodule

// File: tb/sv/scanline_filter_reconstruct_tb.sv
// ----------------------------------------------------------------------------
// scanline_filter_reconstruct_tb: self-checking bench for scanline rebuild
// Drives filter-type and data bytes through the input stream, shadows the
// line store and neighbor history to predict every rebuilt byte, and checks
// each output request in order. A directed table runs first, then random
// rows over several row lengths, pixel widths and handshake stall patterns.
// ----------------------------------------------------------------------------
module scanline_filter_reconstruct_tb;
  import sfr_pkg::*;

  // one rebuilt byte as seen on the output stream
  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       bad_filter;
  } pix_result_t;

  // directed row: stimulus plus an optional typed-in result
  typedef struct packed {
    logic [7:0] sbyte;
    logic       start;
    logic       typed;
    logic [7:0] px;
    logic       lst;
    logic       bad;
  } stim_row_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // one configuration setting and how long to run it
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] pix;
    idle_mode_t       mode;
    int               items;
    int               tail;
  } phase_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int NUM_DIRECTED   = 22;
  localparam int NUM_PHASES     = 9;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = 8'h00;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;
  logic             out_tlast;
  logic             out_tuser;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_addr = REG_ROW_BYTES;
  logic [ROW_W-1:0] cfg_data = '0;

  // typed-in result travelling with the current input request
  logic        typed_vld = 1'b0;
  pix_result_t typed_res = '0;

  idle_mode_t  idle_mode = IDLE_NONE;
  int          err_cnt = 0;
  int          idle_cycles = 0;
  pix_result_t pix_expected [$];

  // shadow of the block state
  logic [7:0]        shadow_line [MAX_ROW_BYTES];
  logic [HIST_W-1:0] left_hist = '0;
  logic [HIST_W-1:0] upleft_hist = '0;
  int unsigned       col_cnt = 0;
  filter_t           cur_filter = FLT_NONE;
  bit                on_first_row = 1'b1;
  bit                want_filter = 1'b1;
  bit                stopped = 1'b0;
  logic [ROW_W-1:0]  cfg_row = 15'd1;
  logic [PIX_W-1:0]  cfg_pix = 4'd1;

  // stimulus-side view of row position
  int unsigned gen_rb = 1;
  int unsigned gen_col = 0;
  bit          gen_in_row = 1'b0;
  bit          gen_halted = 1'b0;
  bit          gen_force = 1'b0;

  // directed rows, reset config (one byte per row, one byte pixels)
  stim_row_t dir_rows [NUM_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // filter None, no image start yet
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0},
    '{8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // Up
    '{8'h01, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},  // wraps past 0xFF
    '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // Sub, left edge
    '{8'h80, 1'b0, 1'b1, 8'h80, 1'b1, 1'b0},
    '{8'h03, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // Average
    '{8'h00, 1'b0, 1'b1, 8'h40, 1'b1, 1'b0},
    '{8'h04, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // Paeth
    '{8'h10, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h05, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1},  // lowest bad code
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // dropped
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // dropped
    '{8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},  // restart straight into bad code
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
    '{8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h04, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // image start where data was due
    '{8'hC3, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1},  // highest bad code
    '{8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0}
  };

  // random phases; tail leaves the block that many bytes into a fresh row
  phase_t phases [NUM_PHASES] = '{
    '{15'd0,     4'd0,  IDLE_SEND, 160,   0},
    '{15'd7,     4'd3,  IDLE_RECV, 180,   0},
    '{15'd16,    4'd8,  IDLE_BOTH, 180,   10},
    '{15'd5,     4'd15, IDLE_NONE, 180,   0},
    '{15'd12,    4'd4,  IDLE_SEND, 180,   0},
    '{15'd3,     4'd1,  IDLE_BOTH, 160,   0},
    '{15'd32767, 4'd2,  IDLE_NONE, 60,    0},
    '{15'd9,     4'd8,  IDLE_RECV, 200,   0},
    '{15'd1,     4'd5,  IDLE_BOTH, 120,   0}
  };

  scanline_filter_reconstruct u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_rows(logic [ROW_W-1:0] r);
    if (r == '0) return 1;
    if (r > MAX_ROW_BYTES) return MAX_ROW_BYTES;
    return 32'(r);
  endfunction

  function automatic int unsigned eff_pix(logic [PIX_W-1:0] p);
    if (p == '0) return 1;
    if (p > MAX_PIXEL_BYTES) return MAX_PIXEL_BYTES;
    return 32'(p);
  endfunction

  // Paeth picks the neighbor closest to a + b - c; ties go a, then b
  function automatic int paeth_pick(int a, int b, int c);
    int p;
    int pa;
    int pb;
    int pc;
    p  = a + b - c;
    pa = (p > a) ? p - a : a - p;
    pb = (p > b) ? p - b : b - p;
    pc = (p > c) ? p - c : c - p;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // advance the shadow state by one accepted byte
  task automatic rebuild_byte(input logic [7:0] sb, input logic st,
                              output bit has, output pix_result_t r);
    int unsigned rb;
    int unsigned shift;
    int unsigned col;
    int          a;
    int          b;
    int          c;
    int          pred;
    logic [7:0]  x;
    has   = 1'b0;
    r     = '0;
    rb    = eff_rows(cfg_row);
    shift = (eff_pix(cfg_pix) - 1) * 8;
    if (st) begin
      on_first_row = 1'b1;
      want_filter  = 1'b1;
      stopped      = 1'b0;
      col_cnt      = 0;
    end
    if (stopped) return;
    // filter-type byte
    if (want_filter) begin
      if (sb > FLT_MAX_CODE) begin
        stopped      = 1'b1;
        has          = 1'b1;
        r.bad_filter = 1'b1;
        return;
      end
      cur_filter  = filter_t'(sb[2:0]);
      want_filter = 1'b0;
      col_cnt     = 0;
      left_hist   = '0;
      upleft_hist = '0;
      return;
    end
    // data byte
    col = col_cnt % MAX_ROW_BYTES;
    a   = int'(left_hist[shift +: 8]);
    c   = int'(upleft_hist[shift +: 8]);
    b   = on_first_row ? 0 : int'(shadow_line[col]);
    case (cur_filter)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = (a + b) >> 1;
      FLT_PAETH: pred = paeth_pick(a, b, c);
      default:   pred = 0;
    endcase
    x = sb + 8'(pred);
    shadow_line[col] = x;
    left_hist   = {left_hist[HIST_W-9:0], x};
    upleft_hist = {upleft_hist[HIST_W-9:0], 8'(b)};
    col_cnt     = col + 1;
    has         = 1'b1;
    r.pixel     = x;
    if (col_cnt >= rb) begin
      r.row_end    = 1'b1;
      col_cnt      = 0;
      want_filter  = 1'b1;
      on_first_row = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // scoreboard and watchdog; output popped before input pushes at one edge
  always @(posedge clk) begin : scoreboard
    bit          has_res;
    bit          moved;
    pix_result_t want;
    pix_result_t got;
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got   = {out_tdata, out_tlast, out_tuser};
        if (pix_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result %02h last %0b bad %0b",
                                    got.pixel, got.row_end, got.bad_filter));
        end else begin
          want = pix_expected.pop_front();
          if (got.pixel !== want.pixel)
            report_mismatch($sformatf("pixel_byte %02h, want %02h", got.pixel, want.pixel));
          if (got.row_end !== want.row_end)
            report_mismatch($sformatf("row_end %0b, want %0b", got.row_end, want.row_end));
          if (got.bad_filter !== want.bad_filter)
            report_mismatch($sformatf("bad_filter %0b, want %0b",
                                      got.bad_filter, want.bad_filter));
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        rebuild_byte(in_tdata, in_tuser, has_res, want);
        if (typed_vld) pix_expected.push_back(typed_res);
        else if (has_res) pix_expected.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_addr == REG_ROW_BYTES) cfg_row = cfg_data;
        else cfg_pix = cfg_data[PIX_W-1:0];
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("scanline_filter_reconstruct_tb: errors");
        $finish;
      end
    end
  end

  // output side back-pressure
  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_tready <= ($urandom_range(0, 99) >= 62);
      IDLE_BOTH: out_tready <= ($urandom_range(0, 99) >= 33);
      default:   out_tready <= 1'b1;
    endcase
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 62;
      IDLE_BOTH: return $urandom_range(0, 99) < 33;
      default:   return 1'b0;
    endcase
  endfunction

  // present one input request and wait for its handshake
  task automatic send_byte(input logic [7:0] sb, input logic st,
                           input logic typed, input pix_result_t tr);
    while (sender_idles()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sb;
    in_tuser  <= st;
    typed_vld <= typed;
    typed_res <= tr;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and let every expected result come out
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pix_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write both registers back to back; a longer row needs a new image
  task automatic set_config(input logic [ROW_W-1:0] row, input logic [PIX_W-1:0] pix);
    int unsigned new_rb;
    cfg_valid <= 1'b1;
    cfg_addr  <= REG_ROW_BYTES;
    cfg_data  <= row;
    do @(posedge clk); while (!cfg_ready);
    cfg_addr  <= REG_PIXEL_BYTES;
    cfg_data  <= {11'($urandom), pix};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    new_rb = eff_rows(row);
    if (new_rb > gen_rb) gen_force = 1'b1;
    gen_rb = new_rb;
  endtask

  // mostly well-formed rows with random content, some broken ones
  task automatic run_phase(input int n_items);
    logic [7:0] sb;
    logic       st;
    int         counted;
    bit         paused;
    counted = 0;
    paused  = 1'b0;
    while (counted < n_items) begin
      if (!paused && counted >= n_items / 2) begin
        settle();
        paused = 1'b1;
      end
      if (gen_halted) begin
        // after a bad filter only an image start gets through
        if ($urandom_range(0, 3) == 0) begin
          st = 1'b1;
          sb = 8'($urandom_range(0, 4));
          gen_halted = 1'b0;
          gen_in_row = 1'b1;
          gen_col    = 0;
          counted++;
        end else begin
          st = 1'b0;
          sb = 8'($urandom);
        end
      end else if (!gen_in_row || gen_force) begin
        st = gen_force || ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 29) == 0) sb = 8'($urandom_range(5, 255));
        else sb = 8'($urandom_range(0, 4));
        gen_force = 1'b0;
        if (sb > FLT_MAX_CODE) begin
          gen_halted = 1'b1;
        end else begin
          gen_in_row = 1'b1;
          gen_col    = 0;
        end
        counted++;
      end else if ($urandom_range(0, 59 + 4 * gen_rb) == 0) begin
        // image start cutting a row short
        st = 1'b1;
        sb = 8'($urandom_range(0, 4));
        gen_col = 0;
        counted++;
      end else begin
        st = 1'b0;
        if ($urandom_range(0, 7) == 0) sb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else sb = 8'($urandom);
        gen_col++;
        if (gen_col >= gen_rb) begin
          gen_in_row = 1'b0;
          gen_col    = 0;
        end
        counted++;
      end
      send_byte(sb, st, 1'b0, '0);
    end
  endtask

  initial begin
    pix_result_t tr;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at reset settings
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      tr = {dir_rows[i].px, dir_rows[i].lst, dir_rows[i].bad};
      send_byte(dir_rows[i].sbyte, dir_rows[i].start, dir_rows[i].typed, tr);
    end
    settle();

    // random phases over the settings
    for (int k = 0; k < NUM_PHASES; k++) begin
      set_config(phases[k].row, phases[k].pix);
      idle_mode = phases[k].mode;
      run_phase(phases[k].items);
      if (phases[k].tail > 0) begin
        send_byte(8'($urandom_range(0, 4)), 1'b1, 1'b0, '0);
        gen_halted = 1'b0;
        gen_force  = 1'b0;
        gen_in_row = 1'b1;
        gen_col    = 0;
        repeat (phases[k].tail) begin
          send_byte(8'($urandom), 1'b0, 1'b0, '0);
          gen_col++;
        end
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("scanline_filter_reconstruct_tb: clean");
    end else begin
      $display("scanline_filter_reconstruct_tb: errors");
    end
    $finish;
  end

endmodule

// File: scanline_filter_reconstruct.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_predict.sv
rtl/core/scanline_filter_reconstruct.sv
tb/sv/scanline_filter_reconstruct_tb.sv
